// ===== design/double_ended_queue_assert.svh =====
// Assertion macros used by the double-ended queue datapath (deq_dp).
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

`define DEQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_ended_queue assertion failed");

`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_ended_queue assertion failed");

`else

`define DEQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/deq_pkg.sv =====
// Types and codes shared by the double-ended queue modules.
// Depends on nothing.
`timescale 1ns / 1ps

package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_DUMP       = 3'd5
  } deq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    RD_FRONT = 2'd0,
    RD_BACK  = 2'd1,
    RD_NEXT  = 2'd2
  } deq_rdsel_t;

  typedef enum logic [2:0] {
    UPD_NONE       = 3'd0,
    UPD_PUSH_FRONT = 3'd1,
    UPD_PUSH_BACK  = 3'd2,
    UPD_POP_FRONT  = 3'd3,
    UPD_POP_BACK   = 3'd4,
    UPD_CLEAR      = 3'd5
  } deq_upd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } deq_state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic [5:0]         count;
    logic               last;
  } deq_out_t;

  typedef struct packed {
    logic        item_load;
    logic        rd_en;
    deq_rdsel_t  rd_sel;
    logic        wr_en;
    deq_upd_t    upd;
    logic        dump_clr;
    logic        dump_inc;
    logic        res_load;
    deq_status_t res_status;
    logic        res_use_rd;
    logic        res_last;
  } deq_cmd_t;

  typedef struct packed {
    logic [2:0] item_op;
    logic       empty;
    logic       full;
    logic       out_free;
    logic       dump_last;
  } deq_stat_t;

endpackage

// ===== design/deq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/deq_dp.sv =====
// Datapath of the double-ended queue: ring indices, element memory and result register.
// Depends on deq_pkg, deq_ram and double_ended_queue_assert.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module deq_dp #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::deq_in_t   in_data,
  input  deq_pkg::deq_cmd_t  cmd,
  output deq_pkg::deq_stat_t stat,
  output logic               out_valid,
  output deq_pkg::deq_out_t  out_data,
  input  logic               out_stall
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     dump_idx_r, dump_idx_nxt;
  logic [2:0]        op_r;
  logic [31:0]       value_r;
  logic              out_valid_r, out_valid_nxt;
  deq_pkg::deq_out_t out_r, out_nxt;

  logic [AW-1:0] front_m1, front_p1, back_wr, back_rd, next_rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   rd_data;
  logic          out_free;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
    if (sum >= SW'(DEPTH)) begin
      return AW'(sum - SW'(DEPTH));
    end
    return AW'(sum);
  endfunction

  always_comb begin
    front_m1 = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
    front_p1 = wrap(SW'(front_r) + SW'(1));
    back_wr  = wrap(SW'(front_r) + SW'(count_r));
    back_rd  = (count_r == '0) ? front_r : wrap(SW'(front_r) + SW'(count_r) - SW'(1));
    next_rd  = wrap(SW'(front_r) + SW'(dump_idx_r) + SW'(1));
  end

  always_comb begin
    case (cmd.rd_sel)
      deq_pkg::RD_FRONT: rd_addr = front_r;
      deq_pkg::RD_BACK:  rd_addr = back_rd;
      deq_pkg::RD_NEXT:  rd_addr = next_rd;
      default:           rd_addr = front_r;
    endcase
    wr_addr = (op_r == deq_pkg::OP_PUSH_FRONT) ? front_m1 : back_wr;
  end

  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    case (cmd.upd)
      deq_pkg::UPD_NONE: begin
      end
      deq_pkg::UPD_PUSH_FRONT: begin
        front_nxt = front_m1;
        count_nxt = count_r + 1'b1;
      end
      deq_pkg::UPD_PUSH_BACK: begin
        count_nxt = count_r + 1'b1;
      end
      deq_pkg::UPD_POP_FRONT: begin
        front_nxt = front_p1;
        count_nxt = count_r - 1'b1;
      end
      deq_pkg::UPD_POP_BACK: begin
        count_nxt = count_r - 1'b1;
      end
      deq_pkg::UPD_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dump_idx_nxt = dump_idx_r;
    if (cmd.dump_clr) begin
      dump_idx_nxt = '0;
    end else if (cmd.dump_inc) begin
      dump_idx_nxt = dump_idx_r + 1'b1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r;
    if (cmd.res_load) begin
      out_nxt.status   = cmd.res_status;
      out_nxt.data_out = cmd.res_use_rd ? rd_data : '0;
      out_nxt.count    = 6'(count_nxt);
      out_nxt.last     = cmd.res_last;
      out_valid_nxt    = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r    <= in_data.operation;
      value_r <= in_data.value;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    stat.item_op   = op_r;
    stat.empty     = (count_r == '0);
    stat.full      = (count_r == CW'(DEPTH));
    stat.out_free  = out_free;
    stat.dump_last = (SW'(dump_idx_r) + SW'(1) == SW'(count_r));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `DEQ_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `DEQ_ASSERT_IMPLIES(a_front_bound, clk, rst_n, 1'b1, front_r <= AW'(DEPTH - 1))
  `DEQ_ASSERT_IMPLIES(a_no_write_full, clk, rst_n, cmd.wr_en, count_r != CW'(DEPTH))
  `DEQ_ASSERT_IMPLIES(a_result_not_lost, clk, rst_n, cmd.res_load, !out_valid_r || !out_stall)
  `DEQ_ASSERT_NEXT(a_dump_walk_bound, clk, rst_n, cmd.dump_inc, CW'(dump_idx_r) < count_r)

endmodule

// ===== design/deq_ctrl.sv =====
// Controller state machine of the double-ended queue.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_op,
  output logic               in_stall,
  output deq_pkg::deq_cmd_t  cmd,
  input  deq_pkg::deq_stat_t stat
);

  deq_pkg::deq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.rd_sel     = deq_pkg::RD_FRONT;
    cmd.upd        = deq_pkg::UPD_NONE;
    cmd.res_status = deq_pkg::ST_OK;
    case (state_r)
      deq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_op inside {[deq_pkg::OP_PUSH_FRONT:deq_pkg::OP_DUMP]})) begin
          cmd.item_load = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = (in_op == deq_pkg::OP_POP_BACK) ? deq_pkg::RD_BACK
                                                           : deq_pkg::RD_FRONT;
          cmd.dump_clr  = 1'b1;
          state_nxt     = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_last = 1'b1;
          state_nxt    = deq_pkg::S_IDLE;
          case (stat.item_op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              if (stat.full) begin
                cmd.res_status = deq_pkg::ST_FULL;
              end else begin
                cmd.wr_en = 1'b1;
                cmd.upd   = (stat.item_op == deq_pkg::OP_PUSH_FRONT)
                            ? deq_pkg::UPD_PUSH_FRONT : deq_pkg::UPD_PUSH_BACK;
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              if (stat.empty) begin
                cmd.res_status = deq_pkg::ST_EMPTY;
              end else begin
                cmd.res_use_rd = 1'b1;
                cmd.upd        = (stat.item_op == deq_pkg::OP_POP_FRONT)
                                 ? deq_pkg::UPD_POP_FRONT : deq_pkg::UPD_POP_BACK;
              end
            end
            deq_pkg::OP_CLEAR: begin
              if (stat.empty) begin
                cmd.res_status = deq_pkg::ST_EMPTY;
              end else begin
                cmd.upd = deq_pkg::UPD_CLEAR;
              end
            end
            deq_pkg::OP_DUMP: begin
              if (stat.empty) begin
                cmd.res_status = deq_pkg::ST_EMPTY;
              end else begin
                cmd.res_use_rd = 1'b1;
                cmd.res_last   = stat.dump_last;
                if (!stat.dump_last) begin
                  cmd.dump_inc = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = deq_pkg::RD_NEXT;
                  state_nxt    = deq_pkg::S_EXEC;
                end
              end
            end
            default: begin
              cmd.res_load = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values in a ring memory with a front index and a
// count. Push and pop at either end, clear, and dump each take one transaction on the
// input; push, pop and clear return one result, dump returns one result per held value,
// front to back, with last set on the back element (an empty queue gives one result).
// Codes six and seven are dropped with no result. An item is accepted, then executed
// against the registered read of the ring memory, and the next item waits until that
// execute step ends; a dump reads the memory once per value. Results wait in an output
// register, and a stalled output holds the execute step. The memory needs no clearing.
// Depends on deq_pkg, deq_ctrl and deq_dp.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_out_t out_data
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ===== tb/sv/double_ended_queue_tb.sv =====
// Self-checking testbench for double_ended_queue: directed and random deque traffic
// with random idling on both sides, checked result by result against a local predictor.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  deq_pkg::deq_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  deq_pkg::deq_out_t out_data;

  logic signed [31:0] ring_copy [DEPTH];
  logic [4:0]         front_copy;
  logic [5:0]         count_copy;
  deq_pkg::deq_out_t  pending_results [$];
  deq_pkg::deq_out_t  want;

  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_len = 0;
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;

  double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void predict_deque(input deq_pkg::deq_in_t item);
    deq_pkg::deq_out_t res;
    logic [4:0]        idx;
    res = '0;
    res.status = deq_pkg::ST_OK;
    res.last = 1'b1;
    case (item.operation)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (count_copy == DEPTH) begin
          res.status = deq_pkg::ST_FULL;
        end else begin
          if (item.operation == deq_pkg::OP_PUSH_FRONT) begin
            front_copy = front_copy - 5'd1;
            ring_copy[front_copy] = item.value;
          end else begin
            idx = front_copy + count_copy[4:0];
            ring_copy[idx] = item.value;
          end
          count_copy = count_copy + 6'd1;
        end
        res.count = count_copy;
        pending_results.push_back(res);
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (count_copy == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else begin
          if (item.operation == deq_pkg::OP_POP_FRONT) begin
            res.data_out = ring_copy[front_copy];
            front_copy = front_copy + 5'd1;
          end else begin
            idx = front_copy + 5'(count_copy - 6'd1);
            res.data_out = ring_copy[idx];
          end
          count_copy = count_copy - 6'd1;
        end
        res.count = count_copy;
        pending_results.push_back(res);
      end
      deq_pkg::OP_CLEAR: begin
        if (count_copy == 0) begin
          res.status = deq_pkg::ST_EMPTY;
        end else begin
          count_copy = '0;
          front_copy = '0;
        end
        pending_results.push_back(res);
      end
      deq_pkg::OP_DUMP: begin
        if (count_copy == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          pending_results.push_back(res);
        end else begin
          for (int i = 0; i < count_copy; i++) begin
            idx = front_copy + 5'(i);
            res.data_out = ring_copy[idx];
            res.count = count_copy;
            res.last = (i == count_copy - 1);
            pending_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data %0d",
                 $time, out_data.status, out_data.data_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.data_out !== want.data_out) begin
          $display("%0t: data_out mismatch, expected %0d, actual %0d",
                   $time, want.data_out, out_data.data_out);
          mismatch_count++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, want.count, out_data.count);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // The receiver stalls in random bursts while rx_idling is set, or for a long stretch when hold_len is set.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] val);
    deq_pkg::deq_in_t item;
    item.operation = op;
    item.value = val;
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_deque(item);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_operation(input bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
    if (roll < 6 && !filling) return deq_pkg::OP_CLEAR;
    if (roll < 14) return deq_pkg::OP_DUMP;
    if (roll < (filling ? 80 : 45)) begin
      return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
  endfunction

  task automatic test_empty_store();
    send_item(deq_pkg::OP_POP_FRONT, VAL_MAX);
    send_item(deq_pkg::OP_POP_BACK, VAL_MIN);
    send_item(deq_pkg::OP_CLEAR, -32'sd1);
    send_item(deq_pkg::OP_DUMP, 32'sd0);
    send_item(OP_UNUSED_6, VAL_MAX);
    send_item(OP_UNUSED_7, -32'sd1);
  endtask

  task automatic test_push_pop_extremes();
    send_item(deq_pkg::OP_PUSH_BACK, VAL_MAX);
    send_item(deq_pkg::OP_PUSH_FRONT, VAL_MIN);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sd0);
    send_item(deq_pkg::OP_PUSH_FRONT, -32'sd1);
    send_item(OP_UNUSED_7, 32'sd5);
    send_item(deq_pkg::OP_DUMP, 32'sd0);
    send_item(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_item(deq_pkg::OP_POP_BACK, 32'sd0);
    send_item(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_item(deq_pkg::OP_POP_BACK, 32'sd0);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh5a5a5a5a);
    send_item(deq_pkg::OP_PUSH_BACK, 32'sh25a5a5a5);
    send_item(deq_pkg::OP_CLEAR, 32'sd0);
  endtask

  task automatic test_full_store();
    send_item(deq_pkg::OP_CLEAR, 32'sd0);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK, rand_value());
    end
    send_item(deq_pkg::OP_PUSH_FRONT, VAL_MAX);
    send_item(deq_pkg::OP_PUSH_BACK, VAL_MIN);
    send_item(deq_pkg::OP_DUMP, 32'sd0);
    send_item(deq_pkg::OP_POP_BACK, 32'sd0);
    send_item(deq_pkg::OP_PUSH_FRONT, rand_value());
    send_item(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_item(deq_pkg::OP_CLEAR, 32'sd0);
  endtask

  task automatic test_output_backpressure(input int n_items);
    tx_idling = 1'b0;
    hold_len = 150;
    for (int k = 0; k < n_items; k++) begin
      send_item(k < n_items / 2 ? deq_pkg::OP_PUSH_BACK : pick_operation(1'b0),
                rand_value());
    end
    while (hold_len != 0) @(posedge clk);
    tx_idling = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_item(deq_pkg::OP_DUMP, 32'sd0);
    wait_drained();
    send_item(deq_pkg::OP_POP_FRONT, 32'sd0);
    send_item(deq_pkg::OP_DUMP, 32'sd0);
  endtask

  task automatic test_random_traffic(input int n_items);
    bit filling;
    filling = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 25 == 0) filling = ~filling;
      if (k == n_items - 40) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      send_item(pick_operation(filling), rand_value());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    front_copy = '0;
    count_copy = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_push_pop_extremes();
    test_full_store();
    test_output_backpressure(40);
    test_sender_pause();
    test_random_traffic(110);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
